FILE: sv/vmx_pkg.sv
`default_nettype none
package vmx_pkg;

    localparam int MemBytes     = 4096;
    localparam int AddrW        = 12;
    localparam int StackDepth   = 16;
    localparam int SpW          = 4;
    localparam int ScreenWidth  = 64;
    localparam int ScreenHeight = 32;
    localparam int PixW         = 11;
    localparam int ColW         = 6;
    localparam int RowW         = 5;
    localparam logic [AddrW-1:0] PcStart = 12'h200;

    typedef enum logic [1:0] {
        CMD_WRITE = 2'd0,
        CMD_READ  = 2'd1,
        CMD_PIXEL = 2'd2,
        CMD_EXEC  = 2'd3
    } t_cmd;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [11:0] address;
        logic [7:0]  write_data;
        logic [10:0] pixel_index;
        logic [7:0]  random_value;
    } t_in_item;

    typedef struct packed {
        logic [7:0]  read_data;
        logic        pixel_value;
        logic [11:0] program_counter;
        logic [15:0] executed_opcode;
        logic        draw_done;
        logic        beep;
        logic        unknown_opcode;
    } t_out_item;

    typedef enum logic [4:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MEMRD,
        ST_PIXRD,
        ST_FETCH_HI,
        ST_FETCH_LO,
        ST_DECODE,
        ST_DRAW_ROW,
        ST_DRAW_PIX,
        ST_DRAW_WR,
        ST_BCD,
        ST_BLK_ST,
        ST_BLK_LD_RD,
        ST_BLK_LD_WR,
        ST_FINISH,
        ST_REPLY
    } t_state;

    // Commands from the controller to the datapath.
    typedef enum logic [4:0] {
        OP_NONE,
        OP_CLEAR,
        OP_LATCH,
        OP_MEM_WRITE,
        OP_MEM_READ,
        OP_PIX_READ,
        OP_FETCH_HI,
        OP_FETCH_LO,
        OP_DECODE,
        OP_DRAW_ROW,
        OP_DRAW_PIX,
        OP_DRAW_WR,
        OP_BCD,
        OP_BLK_ST,
        OP_BLK_LD_RD,
        OP_BLK_LD_WR,
        OP_FINISH,
        OP_REPLY
    } t_dp_op;

    typedef enum logic [1:0] {
        NX_DONE,
        NX_DRAW,
        NX_BCD,
        NX_BLK
    } t_next_kind;

    typedef struct packed {
        t_dp_op op;
    } t_dp_cmd;

    typedef struct packed {
        logic       clear_done;
        t_next_kind kind;
        logic       blk_store;
        logic       row_last;
        logic       pix_last;
        logic       step_last;
    } t_dp_status;

endpackage
`default_nettype wire

FILE: sv/vmx_ctrl.sv
`default_nettype none
module vmx_ctrl
    import vmx_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_start,
    input  wire logic [1:0] i_cmd,
    input  wire t_dp_status i_status,
    output t_dp_cmd         o_dp_cmd,
    output logic            o_busy
);

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR:     if (i_status.clear_done) n_state = ST_IDLE;
            ST_IDLE: begin
                if (i_start) begin
                    case (t_cmd'(i_cmd))
                        CMD_WRITE: n_state = ST_REPLY;
                        CMD_READ:  n_state = ST_MEMRD;
                        CMD_PIXEL: n_state = ST_PIXRD;
                        default:   n_state = ST_FETCH_HI;
                    endcase
                end
            end
            ST_MEMRD:     n_state = ST_REPLY;
            ST_PIXRD:     n_state = ST_REPLY;
            ST_FETCH_HI:  n_state = ST_FETCH_LO;
            ST_FETCH_LO:  n_state = ST_DECODE;
            ST_DECODE: begin
                case (i_status.kind)
                    NX_DRAW: n_state = i_status.row_last ? ST_FINISH : ST_DRAW_ROW;
                    NX_BCD:  n_state = ST_BCD;
                    NX_BLK:  n_state = i_status.blk_store ? ST_BLK_ST : ST_BLK_LD_RD;
                    default: n_state = ST_FINISH;
                endcase
            end
            ST_DRAW_ROW:  n_state = ST_DRAW_PIX;
            ST_DRAW_PIX:  n_state = ST_DRAW_WR;
            ST_DRAW_WR: begin
                if (i_status.pix_last) begin
                    n_state = i_status.row_last ? ST_FINISH : ST_DRAW_ROW;
                end else begin
                    n_state = ST_DRAW_PIX;
                end
            end
            ST_BCD:       if (i_status.step_last) n_state = ST_FINISH;
            ST_BLK_ST:    if (i_status.step_last) n_state = ST_FINISH;
            ST_BLK_LD_RD: n_state = ST_BLK_LD_WR;
            ST_BLK_LD_WR: n_state = i_status.step_last ? ST_FINISH : ST_BLK_LD_RD;
            ST_FINISH:    n_state = ST_REPLY;
            ST_REPLY:     n_state = ST_IDLE;
            default:      n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_dp_cmd.op = OP_NONE;
        o_busy      = 1'b1;
        case (r_state)
            ST_CLEAR:     o_dp_cmd.op = OP_CLEAR;
            ST_IDLE: begin
                o_busy = 1'b0;
                if (i_start) begin
                    o_dp_cmd.op = (t_cmd'(i_cmd) == CMD_WRITE) ? OP_MEM_WRITE : OP_LATCH;
                end
            end
            ST_MEMRD:     o_dp_cmd.op = OP_MEM_READ;
            ST_PIXRD:     o_dp_cmd.op = OP_PIX_READ;
            ST_FETCH_HI:  o_dp_cmd.op = OP_FETCH_HI;
            ST_FETCH_LO:  o_dp_cmd.op = OP_FETCH_LO;
            ST_DECODE:    o_dp_cmd.op = OP_DECODE;
            ST_DRAW_ROW:  o_dp_cmd.op = OP_DRAW_ROW;
            ST_DRAW_PIX:  o_dp_cmd.op = OP_DRAW_PIX;
            ST_DRAW_WR:   o_dp_cmd.op = OP_DRAW_WR;
            ST_BCD:       o_dp_cmd.op = OP_BCD;
            ST_BLK_ST:    o_dp_cmd.op = OP_BLK_ST;
            ST_BLK_LD_RD: o_dp_cmd.op = OP_BLK_LD_RD;
            ST_BLK_LD_WR: o_dp_cmd.op = OP_BLK_LD_WR;
            ST_FINISH:    o_dp_cmd.op = OP_FINISH;
            ST_REPLY:     o_dp_cmd.op = OP_REPLY;
            default:      o_dp_cmd.op = OP_NONE;
        endcase
    end

endmodule
`default_nettype wire

FILE: sv/vmx_datapath.sv
`default_nettype none
module vmx_datapath
    import vmx_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_in_item i_item,
    input  wire t_dp_cmd  i_dp_cmd,
    output t_dp_status    o_status,
    output logic          o_result_valid,
    output t_out_item     o_result
);

    // Memories. Both are cleared by a sweep after reset.
    logic [7:0] r_mem [MemBytes];
    logic       r_disp [ScreenWidth*ScreenHeight];

    logic [7:0]       r_v [16];
    logic [AddrW-1:0] r_stack [StackDepth];
    logic [AddrW-1:0] r_i, r_pc;
    logic [SpW-1:0]   r_sp;
    logic [7:0]       r_dt, r_st;

    logic [AddrW-1:0] r_clr_cnt;
    logic             r_clr_done;

    t_in_item         r_item;
    logic [7:0]       r_mem_q;
    logic             r_disp_q;
    logic [15:0]      r_op;
    logic [AddrW-1:0] r_next;
    logic             r_unk, r_drew, r_hit;
    logic [3:0]       r_row;     // current sprite row
    logic [2:0]       r_col;     // current sprite column
    logic [7:0]       r_sprite;
    logic [3:0]       r_step;
    logic [7:0]       r_bcd_val;
    t_next_kind       r_kind;
    logic [ColW-1:0]  r_x0;
    logic [RowW-1:0]  r_y0;
    t_out_item        r_result;
    logic             r_result_valid;

    t_dp_op op;
    assign op = i_dp_cmd.op;

    // Low byte of the opcode: read issued in FETCH_LO, data in r_mem_q during DECODE.
    // Decode takes it straight from there and registers it at the DECODE edge.
    logic [15:0] cur_op;
    assign cur_op = (op == OP_DECODE) ? {r_op[15:8], r_mem_q} : r_op;

    logic [3:0] x, y, n;
    logic [7:0] vx, vy, nn;
    assign x  = cur_op[11:8];
    assign y  = cur_op[7:4];
    assign n  = cur_op[3:0];
    assign nn = cur_op[7:0];
    assign vx = r_v[x];
    assign vy = r_v[y];

    // Memory address mux.
    logic [AddrW-1:0] mem_addr;
    logic [AddrW-1:0] pc_plus1;
    assign pc_plus1 = r_pc + 12'd1;
    always_comb begin
        case (op)
            OP_CLEAR:     mem_addr = r_clr_cnt;
            OP_MEM_WRITE: mem_addr = i_item.address;
            OP_MEM_READ:  mem_addr = r_item.address;
            OP_FETCH_HI:  mem_addr = r_pc;
            OP_FETCH_LO:  mem_addr = pc_plus1;
            default:      mem_addr = r_i + {8'd0, r_step};
        endcase
    end

    // BCD digits: hundreds by compare, tens by reciprocal multiply, units by subtraction.
    logic [7:0]  bcd_hund, bcd_rem, bcd_tens, bcd_ones;
    logic [15:0] bcd_prod;
    assign bcd_hund = (r_bcd_val >= 8'd200) ? 8'd2 :
                      (r_bcd_val >= 8'd100) ? 8'd1 : 8'd0;
    assign bcd_rem  = r_bcd_val - ((r_bcd_val >= 8'd200) ? 8'd200 :
                                   (r_bcd_val >= 8'd100) ? 8'd100 : 8'd0);
    assign bcd_prod = {8'd0, bcd_rem} * 16'd205;
    assign bcd_tens = {3'd0, bcd_prod[15:11]};
    assign bcd_ones = bcd_rem - ({bcd_tens[4:0], 3'b000} + {bcd_tens[6:0], 1'b0});

    logic [7:0] bcd_digit;
    always_comb begin
        case (r_step[1:0])
            2'd0:    bcd_digit = bcd_hund;
            2'd1:    bcd_digit = bcd_tens;
            default: bcd_digit = bcd_ones;
        endcase
    end

    logic       mem_we;
    logic [7:0] mem_wd;
    always_comb begin
        mem_we = 1'b0;
        mem_wd = 8'd0;
        case (op)
            OP_CLEAR:     begin mem_we = 1'b1; mem_wd = 8'd0; end
            OP_MEM_WRITE: begin mem_we = 1'b1; mem_wd = i_item.write_data; end
            OP_BCD:       begin mem_we = 1'b1; mem_wd = bcd_digit; end
            OP_BLK_ST:    begin mem_we = 1'b1; mem_wd = r_v[r_step]; end
            default:      ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_addr] <= mem_wd;
        end
        r_mem_q <= r_mem[mem_addr];
    end

    // Display pixel address.
    logic [ColW-1:0] px;
    logic [RowW-1:0] py;
    logic [PixW-1:0] disp_addr;
    assign px = r_x0 + ColW'(r_col);
    assign py = r_y0 + RowW'(r_row);
    always_comb begin
        case (op)
            OP_CLEAR:    disp_addr = r_clr_cnt[PixW-1:0];
            OP_PIX_READ: disp_addr = r_item.pixel_index;
            default:     disp_addr = {py, px};
        endcase
    end
    logic disp_we, disp_wd, pix_on;
    assign pix_on  = r_sprite[3'd7 - r_col];
    assign disp_we = (op == OP_CLEAR) || (op == OP_DRAW_WR && pix_on);
    assign disp_wd = (op == OP_CLEAR) ? 1'b0 : ~r_disp_q;

    always_ff @(posedge i_clk) begin
        if (disp_we) begin
            r_disp[disp_addr] <= disp_wd;
        end
        r_disp_q <= r_disp[disp_addr];
    end

    // Decode, combinational on the fetched word.
    logic [AddrW-1:0] dec_next;
    logic             dec_unk;
    t_next_kind       dec_kind;
    logic [AddrW-1:0] pc2, pc4;
    logic [8:0]       sum9;
    assign pc2  = r_pc + 12'd2;
    assign pc4  = r_pc + 12'd4;
    assign sum9 = {1'b0, vx} + {1'b0, vy};
    always_comb begin
        dec_next = pc2;
        dec_unk  = 1'b0;
        dec_kind = NX_DONE;
        case (cur_op[15:12])
            4'h0: begin
                if (cur_op == 16'h00EE) begin
                    dec_next = r_stack[r_sp - SpW'(1)] + 12'd2;
                end else begin
                    dec_unk = 1'b1;
                end
            end
            4'h1, 4'h2: dec_next = cur_op[11:0];
            4'h3: if (vx == nn) dec_next = pc4;
            4'h4: if (vx != nn) dec_next = pc4;
            4'h5: begin
                if (n != 4'd0) dec_unk = 1'b1;
                else if (vx == vy) dec_next = pc4;
            end
            4'h8: begin
                case (n)
                    4'h0, 4'h1, 4'h2, 4'h3, 4'h4, 4'h5, 4'h6, 4'h7, 4'hE: ;
                    default: dec_unk = 1'b1;
                endcase
            end
            4'h9: begin
                if (n != 4'd0) dec_unk = 1'b1;
                else if (vx != vy) dec_next = pc4;
            end
            4'hB: dec_next = cur_op[11:0] + {4'd0, r_v[0]};
            4'hD: dec_kind = NX_DRAW;
            4'hE: dec_unk = 1'b1;
            4'hF: begin
                case (nn)
                    8'h07, 8'h15, 8'h18, 8'h1E: ;
                    8'h33: dec_kind = NX_BCD;
                    8'h55, 8'h65: dec_kind = NX_BLK;
                    default: dec_unk = 1'b1;
                endcase
            end
            default: ;
        endcase
    end

    // Status. The kind is only looked at in the decode cycle.
    assign o_status.clear_done = r_clr_done;
    assign o_status.kind       = dec_kind;
    assign o_status.blk_store  = (nn == 8'h55);
    assign o_status.row_last   = (op == OP_DECODE) ? (n == 4'd0) : (r_row == n - 4'd1);
    assign o_status.pix_last   = (r_col == 3'd7);
    assign o_status.step_last  = (op == OP_BCD) ? (r_step == 4'd2) : (r_step == x);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_cnt      <= '0;
            r_clr_done     <= 1'b0;
            r_pc           <= PcStart;
            r_i            <= '0;
            r_sp           <= '0;
            r_dt           <= '0;
            r_st           <= '0;
            r_kind         <= NX_DONE;
            r_result_valid <= 1'b0;
            for (int k = 0; k < 16; k++) r_v[k] <= 8'd0;
            for (int k = 0; k < StackDepth; k++) r_stack[k] <= '0;
        end else begin
            r_result_valid <= 1'b0;
            case (op)
                OP_CLEAR: begin
                    r_clr_cnt <= r_clr_cnt + 12'd1;
                    if (r_clr_cnt == 12'(MemBytes - 1)) r_clr_done <= 1'b1;
                end
                OP_LATCH:     r_item <= i_item;
                OP_MEM_WRITE: begin
                    r_item   <= i_item;
                    r_result <= '{8'd0, 1'b0, r_pc, 16'd0, 1'b0, 1'b0, 1'b0};
                end
                OP_MEM_READ, OP_PIX_READ: ;
                OP_FETCH_HI: ;
                OP_FETCH_LO: begin
                    r_op[15:8] <= r_mem_q;
                end
                OP_DECODE: begin
                    r_op[7:0] <= r_mem_q;
                    r_next    <= dec_next;
                    r_unk     <= dec_unk;
                    r_kind    <= dec_kind;
                    r_drew    <= 1'b0;
                    r_hit     <= 1'b0;
                    r_row     <= 4'd0;
                    r_col     <= 3'd0;
                    r_step    <= 4'd0;
                    r_bcd_val <= vx;
                    r_x0      <= vx[ColW-1:0];
                    r_y0      <= vy[RowW-1:0];
                    case (cur_op[15:12])
                        4'h0: if (cur_op == 16'h00EE) r_sp <= r_sp - SpW'(1);
                        4'h2: begin
                            r_stack[r_sp] <= r_pc;
                            r_sp <= r_sp + SpW'(1);
                        end
                        4'h6: r_v[x] <= nn;
                        4'h7: r_v[x] <= vx + nn;
                        4'h8: begin
                            // The flag wins over the result when X is F.
                            case (n)
                                4'h0: r_v[x] <= vy;
                                4'h1: r_v[x] <= vx | vy;
                                4'h2: r_v[x] <= vx & vy;
                                4'h3: r_v[x] <= vx ^ vy;
                                4'h4: begin
                                    if (x != 4'hF) r_v[x] <= sum9[7:0];
                                    r_v[15] <= {7'd0, sum9[8]};
                                end
                                4'h5: begin
                                    if (x != 4'hF) r_v[x] <= vx - vy;
                                    r_v[15] <= {7'd0, vx >= vy};
                                end
                                4'h6: begin
                                    if (x != 4'hF) r_v[x] <= {1'b0, vx[7:1]};
                                    r_v[15] <= {7'd0, vx[0]};
                                end
                                4'h7: begin
                                    if (x != 4'hF) r_v[x] <= vy - vx;
                                    r_v[15] <= {7'd0, vy >= vx};
                                end
                                4'hE: begin
                                    if (x != 4'hF) r_v[x] <= {vx[6:0], 1'b0};
                                    r_v[15] <= {7'd0, vx[7]};
                                end
                                default: ;
                            endcase
                        end
                        4'hA: r_i <= cur_op[11:0];
                        4'hC: r_v[x] <= r_item.random_value & nn;
                        4'hF: begin
                            case (nn)
                                8'h07: r_v[x] <= r_dt;
                                8'h15: r_dt <= vx;
                                8'h18: r_st <= vx;
                                8'h1E: r_i <= r_i + {4'd0, vx};
                                default: ;
                            endcase
                        end
                        default: ;
                    endcase
                end
                OP_DRAW_ROW: ;
                OP_DRAW_PIX: begin
                    if (r_col == 3'd0) r_sprite <= r_mem_q;
                end
                OP_DRAW_WR: begin
                    if (pix_on) begin
                        r_drew <= 1'b1;
                        if (r_disp_q) r_hit <= 1'b1;
                    end
                    r_col <= r_col + 3'd1;
                    if (r_col == 3'd7) begin
                        r_row  <= r_row + 4'd1;
                        r_step <= r_step + 4'd1;
                    end
                end
                OP_BCD:    r_step <= r_step + 4'd1;
                OP_BLK_ST: r_step <= r_step + 4'd1;
                OP_BLK_LD_RD: ;
                OP_BLK_LD_WR: begin
                    r_v[r_step] <= r_mem_q;
                    r_step <= r_step + 4'd1;
                end
                OP_FINISH: begin
                    r_pc <= r_next;
                    if (r_kind == NX_DRAW) r_v[15] <= {7'd0, r_hit};
                    if (r_kind == NX_BLK) r_i <= r_i + {8'd0, x} + 12'd1;
                    if (r_dt != 8'd0) r_dt <= r_dt - 8'd1;
                    if (r_st != 8'd0) r_st <= r_st - 8'd1;
                    r_result <= '{8'd0, 1'b0, r_next, r_op, r_drew, (r_st == 8'd1), r_unk};
                end
                OP_REPLY: begin
                    r_result_valid <= 1'b1;
                    if (t_cmd'(r_item.cmd) == CMD_READ) begin
                        r_result <= '{r_mem_q, 1'b0, r_pc, 16'd0, 1'b0, 1'b0, 1'b0};
                    end else if (t_cmd'(r_item.cmd) == CMD_PIXEL) begin
                        r_result <= '{8'd0, r_disp_q, r_pc, 16'd0, 1'b0, 1'b0, 1'b0};
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_result_valid = r_result_valid;
    assign o_result       = r_result;

endmodule
`default_nettype wire

FILE: sv/vm_instruction_execute_core.sv
`default_nettype none
// CHIP-8 style execute core. A command beat is taken at a rising edge with start high and
// busy low, and busy stays high until the core can take the next one. Each beat gives
// exactly one result, shown on o_result with o_result_valid high for a single cycle; the
// receiver cannot stall it, so the result must be captured in that cycle. The strobe is high
// in the first cycle that busy is low again. A sprite draw fetches each row byte and then
// takes a read and a write step for each pixel of the row, BCD writes its three digits in
// turn, a register block store of V0..VX writes one register per step and a block load
// reads and then writes one register per step, all through the single-port memory and
// display. After reset the core clears memory and display with a sweep, keeping busy high
// throughout.
module vm_instruction_execute_core
    import vmx_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      start,
    output logic           busy,
    input  wire t_in_item  i_item,
    output logic           o_result_valid,
    output t_out_item      o_result
);

    t_dp_cmd    dp_cmd;
    t_dp_status dp_status;

    vmx_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_cmd    (i_item.cmd),
        .i_status (dp_status),
        .o_dp_cmd (dp_cmd),
        .o_busy   (busy)
    );

    vmx_datapath u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_item         (i_item),
        .i_dp_cmd       (dp_cmd),
        .o_status       (dp_status),
        .o_result_valid (o_result_valid),
        .o_result       (o_result)
    );

endmodule
`default_nettype wire

FILE: tb/sv/tb_vm_instruction_execute_core.sv
`timescale 1ns / 1ps
`default_nettype none
// Checks the CHIP-8 style execute core against a behavioural copy of the machine kept in
// this bench. Each accepted command beat is applied to the copy at once, and the result
// it should give is queued. Every result strobe is then compared field by field with the
// oldest queued result.
module tb_vm_instruction_execute_core;
    import vmx_pkg::*;

    logic      i_clk;
    logic      i_rst_n;
    logic      start;
    logic      busy;
    t_in_item  i_item;
    logic      o_result_valid;
    t_out_item o_result;

    vm_instruction_execute_core i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_item         (i_item),
        .o_result_valid (o_result_valid),
        .o_result       (o_result)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // The guard time allows for the clearing sweep and for every beat being the slowest kind
    // (a fifteen-row draw) with the longest sender gap, several times over.
    initial begin
        #(1650 * 2000 * 10 + 200000);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Shadow copy of the machine state.
    logic [7:0]  mem_shadow [MemBytes];
    logic        pix_shadow [ScreenWidth*ScreenHeight];
    logic [7:0]  vreg [16];
    logic [11:0] idx_reg;
    logic [11:0] pc_reg;
    logic [11:0] ret_stack [StackDepth];
    logic [SpW-1:0] sp_reg;
    logic [7:0]  delay_tmr;
    logic [7:0]  sound_tmr;

    t_out_item   pending_results[$];
    int          fail_count = 0;

    // One row of the directed table; a set has_gold flag means the expected result was
    // written out by hand and is checked against the predictor as well.
    typedef struct {
        t_in_item  beat;
        logic      has_gold;
        t_out_item gold;
    } t_row;
    t_row directed_rows[$];

    // Runs one execute on the shadow state and returns the expected result.
    function automatic t_out_item run_instruction(logic [7:0] rnd);
        t_out_item   r;
        logic [15:0] op;
        logic [3:0]  x, y, n;
        logic [7:0]  nn, a, b, f, row, ctr;
        logic [11:0] nnn, nxt;
        logic [8:0]  sum;
        int          x0, y0, px, py;
        logic        hit;
        r = '0;
        op = {mem_shadow[pc_reg], mem_shadow[pc_reg + 12'd1]};
        x = op[11:8]; y = op[7:4]; n = op[3:0]; nn = op[7:0]; nnn = op[11:0];
        nxt = pc_reg + 12'd2;
        case (op[15:12])
            4'h0: begin
                if (op == 16'h00EE) begin
                    sp_reg = sp_reg - 1'b1;
                    nxt = ret_stack[sp_reg] + 12'd2;
                end else begin
                    r.unknown_opcode = 1'b1;
                end
            end
            4'h1: nxt = nnn;
            4'h2: begin
                ret_stack[sp_reg] = pc_reg;
                sp_reg = sp_reg + 1'b1;
                nxt = nnn;
            end
            4'h3: if (vreg[x] == nn) nxt = nxt + 12'd2;
            4'h4: if (vreg[x] != nn) nxt = nxt + 12'd2;
            4'h5: begin
                if (n != 0) r.unknown_opcode = 1'b1;
                else if (vreg[x] == vreg[y]) nxt = nxt + 12'd2;
            end
            4'h6: vreg[x] = nn;
            4'h7: vreg[x] = vreg[x] + nn;
            4'h8: begin
                a = vreg[x]; b = vreg[y];
                case (n)
                    4'h0: vreg[x] = b;
                    4'h1: vreg[x] = a | b;
                    4'h2: vreg[x] = a & b;
                    4'h3: vreg[x] = a ^ b;
                    4'h4: begin
                        sum = a + b;
                        vreg[x] = sum[7:0]; vreg[15] = {7'd0, sum[8]};
                    end
                    4'h5: begin f = {7'd0, a >= b}; vreg[x] = a - b; vreg[15] = f; end
                    4'h6: begin f = {7'd0, a[0]}; vreg[x] = a >> 1; vreg[15] = f; end
                    4'h7: begin f = {7'd0, b >= a}; vreg[x] = b - a; vreg[15] = f; end
                    4'hE: begin f = {7'd0, a[7]}; vreg[x] = a << 1; vreg[15] = f; end
                    default: r.unknown_opcode = 1'b1;
                endcase
            end
            4'h9: begin
                if (n != 0) r.unknown_opcode = 1'b1;
                else if (vreg[x] != vreg[y]) nxt = nxt + 12'd2;
            end
            4'hA: idx_reg = nnn;
            4'hB: nxt = nnn + vreg[0];
            4'hC: vreg[x] = rnd & nn;
            4'hD: begin
                // Each set sprite bit flips its pixel; coordinates wrap at the edges.
                x0 = vreg[x] % ScreenWidth;
                y0 = vreg[y] % ScreenHeight;
                hit = 1'b0;
                for (int rr = 0; rr < n; rr++) begin
                    row = mem_shadow[idx_reg + rr[11:0]];
                    for (int c = 0; c < 8; c++) begin
                        if (row[7-c]) begin
                            px = (x0 + c) % ScreenWidth;
                            py = (y0 + rr) % ScreenHeight;
                            if (pix_shadow[py*ScreenWidth + px]) hit = 1'b1;
                            pix_shadow[py*ScreenWidth + px] = ~pix_shadow[py*ScreenWidth + px];
                            r.draw_done = 1'b1;
                        end
                    end
                end
                vreg[15] = {7'd0, hit};
            end
            4'hE: r.unknown_opcode = 1'b1;
            default: begin
                case (nn)
                    8'h07: vreg[x] = delay_tmr;
                    8'h15: delay_tmr = vreg[x];
                    8'h18: sound_tmr = vreg[x];
                    8'h1E: idx_reg = idx_reg + vreg[x];
                    8'h33: begin
                        mem_shadow[idx_reg] = vreg[x] / 100;
                        mem_shadow[idx_reg + 12'd1] = (vreg[x] / 10) % 10;
                        mem_shadow[idx_reg + 12'd2] = vreg[x] % 10;
                    end
                    8'h55: begin
                        for (int i = 0; i <= x; i++) mem_shadow[idx_reg + i[11:0]] = vreg[i];
                        idx_reg = idx_reg + x + 12'd1;
                    end
                    8'h65: begin
                        for (int i = 0; i <= x; i++) vreg[i] = mem_shadow[idx_reg + i[11:0]];
                        idx_reg = idx_reg + x + 12'd1;
                    end
                    default: r.unknown_opcode = 1'b1;
                endcase
            end
        endcase
        pc_reg = nxt;
        r.executed_opcode = op;
        ctr = delay_tmr;
        if (ctr != 0) delay_tmr = ctr - 1'b1;
        if (sound_tmr != 0) begin
            if (sound_tmr == 8'd1) r.beep = 1'b1;
            sound_tmr = sound_tmr - 1'b1;
        end
        return r;
    endfunction

    // Applies one accepted command beat to the shadow state and gives its result.
    function automatic t_out_item predict_core_result(t_in_item it);
        t_out_item r;
        r = '0;
        case (t_cmd'(it.cmd))
            CMD_WRITE: mem_shadow[it.address] = it.write_data;
            CMD_READ:  r.read_data = mem_shadow[it.address];
            CMD_PIXEL: r.pixel_value = pix_shadow[it.pixel_index];
            default:   r = run_instruction(it.random_value);
        endcase
        r.program_counter = pc_reg;
        return r;
    endfunction

    // Result checker: every strobe is compared with the oldest queued result.
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_result_valid) begin
            if (pending_results.size() == 0) begin
                $display("%0t: result with none awaited, actual %h", $time, o_result);
                fail_count++;
            end else begin
                want = pending_results.pop_front();
                if (o_result.read_data !== want.read_data) begin
                    $display("%0t: read_data expected %h actual %h", $time,
                             want.read_data, o_result.read_data);
                    fail_count++;
                end
                if (o_result.pixel_value !== want.pixel_value) begin
                    $display("%0t: pixel_value expected %b actual %b", $time,
                             want.pixel_value, o_result.pixel_value);
                    fail_count++;
                end
                if (o_result.program_counter !== want.program_counter) begin
                    $display("%0t: program_counter expected %h actual %h", $time,
                             want.program_counter, o_result.program_counter);
                    fail_count++;
                end
                if (o_result.executed_opcode !== want.executed_opcode) begin
                    $display("%0t: executed_opcode expected %h actual %h", $time,
                             want.executed_opcode, o_result.executed_opcode);
                    fail_count++;
                end
                if (o_result.draw_done !== want.draw_done) begin
                    $display("%0t: draw_done expected %b actual %b", $time,
                             want.draw_done, o_result.draw_done);
                    fail_count++;
                end
                if (o_result.beep !== want.beep) begin
                    $display("%0t: beep expected %b actual %b", $time,
                             want.beep, o_result.beep);
                    fail_count++;
                end
                if (o_result.unknown_opcode !== want.unknown_opcode) begin
                    $display("%0t: unknown_opcode expected %b actual %b", $time,
                             want.unknown_opcode, o_result.unknown_opcode);
                    fail_count++;
                end
            end
        end
    end

    // Burst state for the sender: beats go back to back within a burst, and a random
    // gap follows each burst. Some bursts run with no gap at all.
    int burst_left = 0;

    // Offers one beat at the falling edge and holds it until the core takes it. The
    // prediction is made at the accepting rising edge, before the next beat is set up.
    task automatic send_beat(t_in_item it);
        t_out_item r;
        int        gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                start <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            burst_left = $urandom_range(1, 20);
        end
        start  <= 1'b1;
        i_item <= it;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        r = predict_core_result(it);
        pending_results.push_back(r);
        burst_left--;
        @(negedge i_clk);
    endtask

    function automatic t_in_item mk_beat(t_cmd c, logic [11:0] ad, logic [7:0] wd,
                                         logic [10:0] pi, logic [7:0] rv);
        t_in_item it;
        it.cmd = c; it.address = ad; it.write_data = wd;
        it.pixel_index = pi; it.random_value = rv;
        return it;
    endfunction

    function automatic t_in_item wr_beat(logic [11:0] ad, logic [7:0] wd);
        return mk_beat(CMD_WRITE, ad, wd, 11'($urandom), 8'($urandom));
    endfunction

    function automatic t_in_item ex_beat(logic [7:0] rv);
        return mk_beat(CMD_EXEC, 12'($urandom), 8'($urandom), 11'($urandom), rv);
    endfunction

    // Queues the two write beats of an instruction word at the given address.
    task automatic plant_op(logic [11:0] at, logic [15:0] op);
        directed_rows.push_back('{wr_beat(at, op[15:8]), 1'b0, '0});
        directed_rows.push_back('{wr_beat(at + 12'd1, op[7:0]), 1'b0, '0});
    endtask

    // Random opcodes, mostly well formed, weighted towards the interesting groups.
    function automatic logic [15:0] random_opcode();
        logic [3:0] grp;
        logic [3:0] x, y;
        x = 4'($urandom); y = 4'($urandom);
        case ($urandom_range(0, 15))
            0:  return $urandom_range(0, 1) ? 16'h00EE : 16'($urandom);
            1:  return {4'h8, x, y, 4'($urandom_range(0, 1) ? 4'hE : $urandom_range(0, 7))};
            2:  return {4'h8, x, y, 4'($urandom)};
            3:  return {4'hD, x, y, 4'($urandom_range(0, 4))};
            4:  return {4'hF, x, 8'h33};
            5:  return {4'hF, 4'($urandom_range(0, 3)), $urandom_range(0, 1) ? 8'h55 : 8'h65};
            6:  return {4'hF, x, 8'h1E};
            7:  return {4'hF, x, $urandom_range(0, 1) ? 8'h15 : 8'h18};
            8:  return {4'hF, x, $urandom_range(0, 1) ? 8'h07 : 8'($urandom)};
            9:  return {4'hA, 12'($urandom)};
            10: return {4'h6, x, 8'($urandom)};
            11: return {4'h7, x, 8'($urandom)};
            12: return {4'hC, x, 8'($urandom)};
            13: return {$urandom_range(0, 1) ? 4'h5 : 4'h9, x, y, 4'($urandom_range(0, 1))};
            14: return {$urandom_range(0, 1) ? 4'h3 : 4'h4, x, 8'($urandom)};
            default: begin
                grp = $urandom_range(0, 2) == 0 ? 4'hE : ($urandom_range(0, 1) ? 4'h2 : 4'hB);
                // Keep jump and call targets inside the program area.
                return {grp, 4'h2 + 4'($urandom_range(0, 1)), 8'($urandom)};
            end
        endcase
    endfunction

    logic [15:0] op;

    initial begin
        i_rst_n = 1'b0;
        start   = 1'b0;
        i_item  = '0;
        foreach (mem_shadow[k]) mem_shadow[k] = '0;
        foreach (pix_shadow[k]) pix_shadow[k] = 1'b0;
        foreach (vreg[k]) vreg[k] = '0;
        foreach (ret_stack[k]) ret_stack[k] = '0;
        idx_reg = '0; pc_reg = PcStart; sp_reg = '0; delay_tmr = '0; sound_tmr = '0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed part: extremes of the fields, some instruction groups, and the corner cases
        // (stack wrap, flag written after VX, a draw with N of zero, BCD of VF).
        directed_rows.push_back('{mk_beat(CMD_READ, 12'hFFF, 8'h00, 11'h7FF, 8'hFF), 1'b1,
                                   '{8'h00, 1'b0, 12'h200, 16'h0000, 1'b0, 1'b0, 1'b0}});
        directed_rows.push_back('{mk_beat(CMD_PIXEL, 12'h000, 8'hFF, 11'h7FF, 8'h00), 1'b1,
                                   '{8'h00, 1'b0, 12'h200, 16'h0000, 1'b0, 1'b0, 1'b0}});
        directed_rows.push_back('{wr_beat(12'hFFF, 8'hFF), 1'b0, '0});
        directed_rows.push_back('{mk_beat(CMD_READ, 12'hFFF, 8'h00, 11'h000, 8'h00), 1'b1,
                                   '{8'hFF, 1'b0, 12'h200, 16'h0000, 1'b0, 1'b0, 1'b0}});
        // An all-zero word at 0x200 is a machine routine call: unknown, pc steps by two.
        directed_rows.push_back('{ex_beat(8'h00), 1'b1,
                                   '{8'h00, 1'b0, 12'h202, 16'h0000, 1'b0, 1'b0, 1'b1}});
        plant_op(12'h202, 16'h6FFF);
        plant_op(12'h204, 16'h8FFE);
        plant_op(12'h206, 16'hA000);
        plant_op(12'h208, 16'hD017);
        plant_op(12'h20A, 16'hD010);
        plant_op(12'h20C, 16'hFF33);
        plant_op(12'h20E, 16'h00EE);
        foreach (directed_rows[k]) begin
            send_beat(directed_rows[k].beat);
            if (directed_rows[k].has_gold && pending_results[$] != directed_rows[k].gold) begin
                $display("%0t: directed row %0d expected %h actual %h", $time, k,
                         directed_rows[k].gold, pending_results[$]);
                fail_count++;
            end
        end
        // Run the planted program; the return pops an empty stack and so wraps.
        repeat (7) send_beat(ex_beat(8'($urandom)));
        // Raise the sound timer so that a beep is seen shortly.
        plant_op(pc_reg, 16'h6003);
        plant_op(pc_reg + 12'd2, 16'hF018);
        foreach (directed_rows[k]) if (k >= directed_rows.size() - 4)
            send_beat(directed_rows[k].beat);
        repeat (6) send_beat(ex_beat(8'hFF));

        // Let every expected result drain at least once before the random part.
        start <= 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);

        // Random part: mostly instruction words planted just ahead of pc and then run,
        // with stray reads, pixel reads and wild writes mixed in.
        for (int k = 0; k < 800; k++) begin
            case ($urandom_range(0, 9))
                0: send_beat(mk_beat(CMD_READ, 12'($urandom), 8'($urandom),
                                     11'($urandom), 8'($urandom)));
                1: send_beat(mk_beat(CMD_PIXEL, 12'($urandom), 8'($urandom),
                                     11'($urandom), 8'($urandom)));
                2: send_beat(wr_beat(12'($urandom), 8'($urandom)));
                3, 4: send_beat(ex_beat(8'($urandom)));
                default: begin
                    op = random_opcode();
                    send_beat(wr_beat(pc_reg, op[15:8]));
                    send_beat(wr_beat(pc_reg + 12'd1, op[7:0]));
                    send_beat(ex_beat(8'($urandom)));
                end
            endcase
            // Pull a runaway program counter back towards the program area now and then.
            if (pc_reg < 12'h200 && $urandom_range(0, 3) == 0) begin
                send_beat(wr_beat(pc_reg, 8'h12));
                send_beat(wr_beat(pc_reg + 12'd1, 8'h00));
                send_beat(ex_beat(8'h00));
            end
        end

        start <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (400) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule
